// ===== design/us2cal_pkg.sv =====
// Shared types, constants and the month length table for the calendar converter.
`default_nettype none
package us2cal_pkg;

   localparam int unsigned EpochYear   = 1970;
   localparam int unsigned UnitWidth   = 16;
   localparam int unsigned ReqWidth    = 32;
   localparam int unsigned RspWidth    = 40;

   localparam logic [UnitWidth-1:0] SecsPerMin  = 16'd60;
   localparam logic [UnitWidth-1:0] MinsPerHour = 16'd60;
   localparam logic [UnitWidth-1:0] HoursPerDay = 16'd24;
   localparam logic [UnitWidth-1:0] DaysShort   = 16'd365;
   localparam logic [UnitWidth-1:0] DaysLong    = 16'd366;

   // Reciprocals for exact unsigned 32-bit division by 60 and by 24, with their shifts.
   localparam logic [ReqWidth-1:0] RecipBy60 = 32'h8888_8889;
   localparam logic [ReqWidth-1:0] RecipBy24 = 32'hAAAA_AAAB;
   localparam int unsigned         ShiftBy60 = 37;
   localparam int unsigned         ShiftBy24 = 36;

   // Year mod 100 and mod 400 at the epoch.
   localparam logic [6:0] EpochMod100 = 7'd70;
   localparam logic [8:0] EpochMod400 = 9'd370;

   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } us2cal_result_type;

   // Length of month mo (0 is January), with February lengthened in a long year.
   function automatic logic [4:0] month_days(input logic [3:0] mo, input logic long_yr);
      logic [4:0] len;
      begin
         case (mo)
            4'd1: begin
               len = long_yr ? 5'd29 : 5'd28;
            end
            4'd3, 4'd5, 4'd8, 4'd10: begin
               len = 5'd30;
            end
            default: begin
               len = 5'd31;
            end
         endcase
         return len;
      end
   endfunction

endpackage
`default_nettype wire

// ===== design/unix_seconds_to_calendar.sv =====
// Unix seconds to calendar date and time, one shared subtract unit under a sequencer.
// Each constant division is a reciprocal multiply followed by a remainder step; then the
// year loop subtracts one whole year per step and the month loop one whole month per step;
// the last step waits while a result is unsent.
// One item at a time: a new request is taken only while the sequencer is idle.
// Reset (synchronous, active high) returns the sequencer to idle and empties the output.
`default_nettype none
module unix_seconds_to_calendar (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [us2cal_pkg::ReqWidth-1:0]   req_tdata,  // epoch_seconds[31:0]
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [us2cal_pkg::RspWidth-1:0]        rsp_tdata   // year[11:0], month[15:12],
                                                              // day[20:16], hour[25:21],
                                                              // minute[31:26], second[37:32]
);
   import us2cal_pkg::*;

   logic              idle;
   logic              push;
   logic              start;
   us2cal_result_type result;
   us2cal_result_type out_ff, out_in;
   logic              valid_ff, valid_in;

   assign req_tready = idle;
   assign start      = req_tvalid & idle;

   us2cal_seq u_seq (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .epoch_seconds (req_tdata),
      .out_free      (~valid_ff),
      .idle          (idle),
      .push          (push),
      .result        (result)
   );

   always_comb begin
      valid_in = valid_ff;
      out_in   = out_ff;
      if (valid_ff && rsp_tready) begin
         valid_in = 1'b0;
      end
      if (push) begin
         valid_in = 1'b1;
         out_in   = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      out_ff <= out_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {2'b00, out_ff.second, out_ff.minute, out_ff.hour,
                        out_ff.day, out_ff.month, out_ff.year};

endmodule
`default_nettype wire

// ===== design/us2cal_sub.sv =====
// Shared compare-and-subtract unit used by the year and month loops of the conversion.
`default_nettype none
module us2cal_sub (
   input  wire logic [us2cal_pkg::UnitWidth-1:0] opa,
   input  wire logic [us2cal_pkg::UnitWidth-1:0] opb,
   output logic                                  ge,
   output logic [us2cal_pkg::UnitWidth-1:0]      diff
);
   import us2cal_pkg::*;

   logic [UnitWidth:0] wide;

   always_comb begin
      wide = {1'b0, opa} - {1'b0, opb};
      ge   = ~wide[UnitWidth];
      diff = wide[UnitWidth-1:0];
   end

endmodule
`default_nettype wire

// ===== design/us2cal_seq.sv =====
// Sequencer: three reciprocal-multiply divisions, then the year and month subtraction loops.
`default_nettype none
module us2cal_seq (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic [us2cal_pkg::ReqWidth-1:0]   epoch_seconds,
   input  wire logic                              out_free,
   output logic                                   idle,
   output logic                                   push,
   output us2cal_pkg::us2cal_result_type          result
);
   import us2cal_pkg::*;

   localparam logic [2:0] StIdle  = 3'd0;
   localparam logic [2:0] StDiv   = 3'd1;
   localparam logic [2:0] StYear  = 3'd2;
   localparam logic [2:0] StMonth = 3'd3;
   localparam logic [2:0] StDone  = 3'd4;

   localparam logic [1:0] PhSec  = 2'd0;
   localparam logic [1:0] PhMin  = 2'd1;
   localparam logic [1:0] PhHour = 2'd2;

   logic [2:0]            state_ff, state_in;
   logic [1:0]            phase_ff, phase_in;
   logic                  step_ff, step_in;
   logic [ReqWidth-1:0]   work_ff, work_in;
   logic [ReqWidth-1:0]   quo_ff, quo_in;
   logic [UnitWidth-1:0]  days_ff, days_in;
   logic [11:0]           year_ff, year_in;
   logic [6:0]            mod100_ff, mod100_in;
   logic [8:0]            mod400_ff, mod400_in;
   logic [3:0]            mo_ff, mo_in;
   logic [5:0]            sec_ff, sec_in;
   logic [5:0]            min_ff, min_in;
   logic [4:0]            hour_ff, hour_in;

   logic [UnitWidth-1:0]  opa, opb, diff;
   logic                  ge;
   logic                  long_yr;
   logic [ReqWidth-1:0]   recip;
   logic [5:0]            divisor;
   logic [2*ReqWidth-1:0] product;
   logic [ReqWidth-1:0]   quo_next;
   logic [11:0]           quo_times_div;
   logic [5:0]            rmd_next;

   us2cal_sub u_sub (
      .opa  (opa),
      .opb  (opb),
      .ge   (ge),
      .diff (diff)
   );

   assign long_yr = ((year_ff[1:0] == 2'd0) && (mod100_ff != 7'd0)) || (mod400_ff == 9'd0);

   // Operand selection for the shared unit.
   always_comb begin
      opa = days_ff;
      case (state_ff)
         StYear: begin
            opb = long_yr ? DaysLong : DaysShort;
         end
         StMonth: begin
            opb = {{(UnitWidth-5){1'b0}}, month_days(mo_ff, long_yr)};
         end
         default: begin
            opb = DaysShort;
         end
      endcase
   end

   // A reciprocal multiply gives the quotient; the remainder is below 64, so only the
   // low six bits of dividend and quotient times divisor are needed to form it.
   always_comb begin
      case (phase_ff)
         PhSec: begin
            recip   = RecipBy60;
            divisor = SecsPerMin[5:0];
         end
         PhMin: begin
            recip   = RecipBy60;
            divisor = MinsPerHour[5:0];
         end
         default: begin
            recip   = RecipBy24;
            divisor = HoursPerDay[5:0];
         end
      endcase
      product = {{ReqWidth{1'b0}}, work_ff} * {{ReqWidth{1'b0}}, recip};
      if (phase_ff == PhHour) begin
         quo_next = ReqWidth'(product >> ShiftBy24);
      end else begin
         quo_next = ReqWidth'(product >> ShiftBy60);
      end
      quo_times_div = {6'd0, quo_ff[5:0]} * {6'd0, divisor};
      rmd_next      = work_ff[5:0] - quo_times_div[5:0];
   end

   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      step_in   = step_ff;
      work_in   = work_ff;
      quo_in    = quo_ff;
      days_in   = days_ff;
      year_in   = year_ff;
      mod100_in = mod100_ff;
      mod400_in = mod400_ff;
      mo_in     = mo_ff;
      sec_in    = sec_ff;
      min_in    = min_ff;
      hour_in   = hour_ff;
      push      = 1'b0;
      case (state_ff)
         StIdle: begin
            if (start) begin
               state_in = StDiv;
               phase_in = PhSec;
               step_in  = 1'b0;
               work_in  = epoch_seconds;
            end
         end
         StDiv: begin
            if (!step_ff) begin
               quo_in  = quo_next;
               step_in = 1'b1;
            end else begin
               // The quotient feeds the next division; the remainder is a field.
               step_in = 1'b0;
               work_in = quo_ff;
               case (phase_ff)
                  PhSec: begin
                     sec_in   = rmd_next;
                     phase_in = PhMin;
                  end
                  PhMin: begin
                     min_in   = rmd_next;
                     phase_in = PhHour;
                  end
                  default: begin
                     hour_in   = rmd_next[4:0];
                     days_in   = quo_ff[UnitWidth-1:0];
                     year_in   = 12'(EpochYear);
                     mod100_in = EpochMod100;
                     mod400_in = EpochMod400;
                     state_in  = StYear;
                  end
               endcase
            end
         end
         StYear: begin
            if (ge) begin
               days_in   = diff;
               year_in   = year_ff + 1'b1;
               mod100_in = (mod100_ff == 7'd99) ? 7'd0 : mod100_ff + 1'b1;
               mod400_in = (mod400_ff == 9'd399) ? 9'd0 : mod400_ff + 1'b1;
            end else begin
               mo_in    = '0;
               state_in = StMonth;
            end
         end
         StMonth: begin
            if (ge && (mo_ff != 4'd11)) begin
               days_in = diff;
               mo_in   = mo_ff + 1'b1;
            end else begin
               state_in = StDone;
            end
         end
         StDone: begin
            if (out_free) begin
               push     = 1'b1;
               state_in = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
      end else begin
         state_ff <= state_in;
      end
      phase_ff  <= phase_in;
      step_ff   <= step_in;
      work_ff   <= work_in;
      quo_ff    <= quo_in;
      days_ff   <= days_in;
      year_ff   <= year_in;
      mod100_ff <= mod100_in;
      mod400_ff <= mod400_in;
      mo_ff     <= mo_in;
      sec_ff    <= sec_in;
      min_ff    <= min_in;
      hour_ff   <= hour_in;
   end

   assign idle = (state_ff == StIdle);

   always_comb begin
      result.year   = year_ff;
      result.month  = mo_ff + 1'b1;
      result.day    = days_ff[4:0] + 1'b1;
      result.hour   = hour_ff;
      result.minute = min_ff;
      result.second = sec_ff;
   end

endmodule
`default_nettype wire
